// File: sv/nle_pkg.sv
// Shared types and constants for the normalized landmark error unit.
package nle_pkg;

  // Fixed field widths
  localparam int FIELD_W   = 16;
  localparam int OUT_W     = 32;
  localparam int SUM_W     = 24;
  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = SUM_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_EYE = 2'd1,
    STAT_FEW      = 2'd2,
    STAT_SAT      = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // latch an input transaction
    logic capture_eye;  // hold target as first eye
    logic sel_eye;      // operands: first eye vs target (else target vs prediction)
    logic sq_first;     // square y difference, clear root unit
    logic sq_second;    // add square of x difference
    logic root_step;    // one digit of the square root
    logic commit_eye;   // root becomes eye distance
    logic commit_sum;   // root added to distance sum, count advances
    logic div_init;     // load dividend, clear remainder
    logic div_step;     // one quotient bit
    logic emit;         // load output register, clear sample
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic count_lt_max;
    logic last;
    logic div_needed;
    logic out_free;
  } stat_t;

endpackage

// File: sv/nle_ctrl.sv
// Controller state machine sequencing squares, square roots and the final division.
module nle_ctrl #(
  parameter int ROOT_STEPS = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  nle_pkg::stat_t stat,
  output nle_pkg::cmd_t  cmd
);
  import nle_pkg::*;

  typedef enum logic [2:0] {
    IDLE, CHECK, SQ_Y, SQ_X, ROOT, COMMIT, FINISH, DIVIDE
  } state_t;

  // FINISH waits for the divider (when used) and then the output slot
  state_t            state;
  logic [STEP_W-1:0] step_cnt;
  logic              eye_phase;
  logic              div_done;

  // State register and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step_cnt  <= '0;
      eye_phase <= 1'b0;
      div_done  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) state <= CHECK;
        end
        CHECK: begin
          if (stat.count_lt_max) begin
            eye_phase <= stat.count_one;
            state     <= SQ_Y;
          end else if (stat.last) begin
            div_done <= 1'b0;
            state    <= FINISH;
          end else begin
            state <= IDLE;
          end
        end
        SQ_Y: state <= SQ_X;
        SQ_X: begin
          step_cnt <= '0;
          state    <= ROOT;
        end
        ROOT: begin
          if (step_cnt == STEP_W'(ROOT_STEPS - 1)) state <= COMMIT;
          else step_cnt <= step_cnt + 1'b1;
        end
        COMMIT: begin
          if (eye_phase) begin
            eye_phase <= 1'b0;
            state     <= SQ_Y;
          end else if (stat.last) begin
            div_done <= 1'b0;
            state    <= FINISH;
          end else begin
            state <= IDLE;
          end
        end
        FINISH: begin
          if (stat.div_needed && !div_done) begin
            step_cnt <= '0;
            state    <= DIVIDE;
          end else if (stat.out_free) begin
            state <= IDLE;
          end
        end
        DIVIDE: begin
          if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
            div_done <= 1'b1;
            state    <= FINISH;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign s_tready = (state == IDLE);

  // Command decode
  always_comb begin
    cmd             = '0;
    cmd.load        = (state == IDLE) && s_tvalid;
    cmd.capture_eye = (state == CHECK) && stat.count_lt_max && stat.count_zero;
    cmd.sel_eye     = eye_phase;
    cmd.sq_first    = (state == SQ_Y);
    cmd.sq_second   = (state == SQ_X);
    cmd.root_step   = (state == ROOT);
    cmd.commit_eye  = (state == COMMIT) && eye_phase;
    cmd.commit_sum  = (state == COMMIT) && !eye_phase;
    cmd.div_init    = (state == FINISH) && stat.div_needed && !div_done;
    cmd.div_step    = (state == DIVIDE);
    cmd.emit        = (state == FINISH) && !(stat.div_needed && !div_done) && stat.out_free;
  end

endmodule

// File: sv/nle_datapath.sv
// Datapath: landmark registers, squarer, digit-serial square root, divider, result register.
module nle_datapath #(
  parameter int MAX_LANDMARKS = 64,
  parameter int COORD_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [4*nle_pkg::FIELD_W-1:0] s_tdata,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [nle_pkg::OUT_W-1:0]    m_tdata,
  output logic [1:0]                   m_tuser,
  input  nle_pkg::cmd_t                cmd,
  output nle_pkg::stat_t               stat
);
  import nle_pkg::*;

  localparam int CW        = COORD_BITS;
  localparam int D_W       = CW + 1;
  localparam int ACC_W     = 2 * D_W;
  localparam int REM_W     = D_W + 2;
  localparam int CNT_W     = $clog2(MAX_LANDMARKS + 1);
  localparam int SUM_EXT_W = ((D_W > SUM_W) ? D_W : SUM_W) + 1;

  // Coordinates from the input fields
  logic signed [CW-1:0] in_ty, in_tx, in_py, in_px;

  if (CW <= FIELD_W) begin : g_narrow
    assign in_ty = s_tdata[0*FIELD_W +: CW];
    assign in_tx = s_tdata[1*FIELD_W +: CW];
    assign in_py = s_tdata[2*FIELD_W +: CW];
    assign in_px = s_tdata[3*FIELD_W +: CW];
  end else begin : g_wide
    assign in_ty = {{(CW-FIELD_W){1'b0}}, s_tdata[0*FIELD_W +: FIELD_W]};
    assign in_tx = {{(CW-FIELD_W){1'b0}}, s_tdata[1*FIELD_W +: FIELD_W]};
    assign in_py = {{(CW-FIELD_W){1'b0}}, s_tdata[2*FIELD_W +: FIELD_W]};
    assign in_px = {{(CW-FIELD_W){1'b0}}, s_tdata[3*FIELD_W +: FIELD_W]};
  end

  logic signed [CW-1:0] ty, tx, py, px;
  logic                 last;
  logic signed [CW-1:0] eye_y, eye_x;
  logic [D_W-1:0]       eye_distance;
  logic [SUM_W-1:0]     distance_sum;
  logic [CNT_W-1:0]     landmark_count;

  logic [ACC_W-1:0]     acc;
  logic [REM_W-1:0]     root_rem;
  logic [D_W-1:0]       root;

  logic [D_W-1:0]       div_rem;
  logic [DIV_STEPS-1:0] div_q;

  logic                 out_valid;
  logic [OUT_W-1:0]     out_value;
  status_t              out_status;

  // Operand select and square of one difference
  logic signed [CW-1:0] op_a, op_b;
  logic signed [D_W-1:0] diff;
  logic [D_W-1:0]       mag;
  logic [ACC_W-1:0]     square;

  always_comb begin
    if (cmd.sel_eye) begin
      op_a = cmd.sq_first ? eye_y : eye_x;
      op_b = cmd.sq_first ? ty : tx;
    end else begin
      op_a = cmd.sq_first ? ty : tx;
      op_b = cmd.sq_first ? py : px;
    end
    diff   = D_W'(op_a) - D_W'(op_b);
    mag    = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
    square = ACC_W'(mag) * ACC_W'(mag);
  end

  // Square root digit: two radicand bits in, one root bit out
  logic [REM_W+1:0] rem_sh, trial, rem_diff;
  always_comb begin
    rem_sh   = {root_rem, acc[ACC_W-1 -: 2]};
    trial    = {2'b00, root, 2'b01};
    rem_diff = rem_sh - trial;
  end

  // Division step: one quotient bit
  logic [D_W:0] drem_sh, drem_diff;
  always_comb begin
    drem_sh   = {div_rem, div_q[DIV_STEPS-1]};
    drem_diff = drem_sh - {1'b0, eye_distance};
  end

  // Saturating sum update
  logic [SUM_EXT_W-1:0] sum_ext;
  assign sum_ext = SUM_EXT_W'(distance_sum) + SUM_EXT_W'(root);

  // Input, root and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ty   <= in_ty;
      tx   <= in_tx;
      py   <= in_py;
      px   <= in_px;
      last <= s_tlast;
    end
    if (cmd.sq_first) begin
      acc      <= square;
      root_rem <= '0;
      root     <= '0;
    end else if (cmd.sq_second) begin
      acc <= acc + square;
    end else if (cmd.root_step) begin
      acc <= {acc[ACC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        root_rem <= rem_diff[REM_W-1:0];
        root     <= {root[D_W-2:0], 1'b1};
      end else begin
        root_rem <= rem_sh[REM_W-1:0];
        root     <= {root[D_W-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      div_rem <= '0;
      div_q   <= {distance_sum, {FRAC_BITS{1'b0}}};
    end else if (cmd.div_step) begin
      if (drem_sh >= {1'b0, eye_distance}) begin
        div_rem <= drem_diff[D_W-1:0];
        div_q   <= {div_q[DIV_STEPS-2:0], 1'b1};
      end else begin
        div_rem <= drem_sh[D_W-1:0];
        div_q   <= {div_q[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // Sample state
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      eye_y          <= '0;
      eye_x          <= '0;
      eye_distance   <= '0;
      distance_sum   <= '0;
      landmark_count <= '0;
    end else begin
      if (cmd.capture_eye) begin
        eye_y <= ty;
        eye_x <= tx;
      end
      if (cmd.commit_eye) eye_distance <= root;
      if (cmd.commit_sum) begin
        distance_sum   <= (sum_ext > SUM_EXT_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
        landmark_count <= landmark_count + 1'b1;
      end
    end
  end

  // Result selection
  logic [OUT_W-1:0] res_value;
  status_t          res_status;
  always_comb begin
    res_value  = '0;
    res_status = STAT_OK;
    if (landmark_count < CNT_W'(2)) begin
      res_status = STAT_FEW;
    end else if (eye_distance == '0) begin
      res_status = STAT_ZERO_EYE;
    end else if (|div_q[DIV_STEPS-1:OUT_W]) begin
      res_value  = '1;
      res_status = STAT_SAT;
    end else begin
      res_value = div_q[OUT_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_status;

  // Status to controller
  always_comb begin
    stat.count_zero   = (landmark_count == '0);
    stat.count_one    = (landmark_count == CNT_W'(1));
    stat.count_lt_max = (landmark_count < CNT_W'(MAX_LANDMARKS));
    stat.last         = last;
    stat.div_needed   = (landmark_count >= CNT_W'(2)) && (eye_distance != '0);
    stat.out_free     = !out_valid || m_tready;
  end

endmodule

// File: sv/normalized_landmark_error_unit.sv
// Normalized landmark error unit: one landmark per input transaction (target and
// predicted y/x, signed Q11.4, tlast marks the last landmark of a sample). The first
// target is held as one eye; the second target sets the inter-eye distance. Each
// landmark's target-to-prediction distance comes from a digit-serial square root that
// yields one root bit per cycle, and the second landmark runs it once more for the eye
// distance. A landmark past MAX_LANDMARKS is dropped. The last landmark runs the
// bit-serial 40-step divider when a division is needed, then waits while an earlier
// result still sits in the output register; after that one result transaction carries
// the sum over the eye distance as unsigned Q16.16 (saturating) with a status code. The
// result sits in an output register, so a new landmark is taken while it waits.
module normalized_landmark_error_unit #(
  parameter int MAX_LANDMARKS = 64,
  parameter int COORD_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // target_y, target_x, predicted_y, predicted_x (16 bits each)
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // error_value (32 bits)
  output logic [31:0] m_tdata,
  // status (2 bits)
  output logic [1:0]  m_tuser
);
  import nle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  nle_ctrl #(
    .ROOT_STEPS(COORD_BITS + 1)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nle_datapath #(
    .MAX_LANDMARKS(MAX_LANDMARKS),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

`ifndef SYNTH
  // One landmark at a time: ready drops right after an input transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a landmark is in work");

  // A result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // Saturated results carry all ones
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == STAT_SAT)) |-> (m_tdata == '1))
    else $error("saturated status without full-scale value");

  // Error statuses carry zero
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser == STAT_FEW) || (m_tuser == STAT_ZERO_EYE))) |-> (m_tdata == '0))
    else $error("error status with nonzero value");
`endif

endmodule
